[src/session_replay_window_macros.svh]
// Assertion macros shared by the session replay window RTL.
`ifndef SESSION_REPLAY_WINDOW_MACROS_SVH
`define SESSION_REPLAY_WINDOW_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SRW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define SRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/srw_pkg.sv]
// Package: widths, codes and types of the session replay window.
`timescale 1ns / 1ps

package srw_pkg;

    localparam int NODES_DEFAULT = 8;

    localparam int MODE_W   = 2;
    localparam int SRC_W    = 8;
    localparam int SESS_W   = 32;
    localparam int SEQ_W    = 16;
    localparam int STATUS_W = 3;

    // sliding window span and the bits needed to index it
    localparam int WINDOW_SPAN = 64;
    localparam int BACK_W      = $clog2(WINDOW_SPAN);
    localparam logic [WINDOW_SPAN-1:0] BIT0 = WINDOW_SPAN'(1);

    // request modes
    localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MARK    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_APPROVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK               = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SESSION_REQUIRED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STALE            = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_ARGUMENT     = 3'd4;

    // one window per source
    typedef struct packed {
        logic                   approved;
        logic [SESS_W-1:0]      session;
        logic [SEQ_W-1:0]       seq_floor;
        logic                   started;
        logic [SEQ_W-1:0]       highest;
        logic [WINDOW_SPAN-1:0] bitmap;
    } win_t;

    // registered request
    typedef struct packed {
        logic              src_ok;
        logic [MODE_W-1:0] mode;
        logic [SESS_W-1:0] msg_session;
        logic [SEQ_W-1:0]  sequence_req;
        logic [SEQ_W-1:0]  seq_floor;
    } req_t;

endpackage

[src/session_replay_window.sv]
// Top level: per-source anti-replay filter with a 64-entry sliding window.
// Requests pass the input register, then the result register that drives done and status.
// Throughput: one request per cycle; busy is never raised.
// Back-to-back requests to one source are handled by forwarding the window write to the read.
// Reset clears every window (approved, session, floor, started, highest, bitmap) at once.
// The receiver cannot stall; each status is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "session_replay_window_macros.svh"

module session_replay_window #(
    parameter int unsigned NODES = srw_pkg::NODES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [srw_pkg::MODE_W-1:0]     mode,
    input  logic [srw_pkg::SRC_W-1:0]      source,
    input  logic [srw_pkg::SESS_W-1:0]     msg_session,
    input  logic [srw_pkg::SEQ_W-1:0]      sequence_req,
    input  logic [srw_pkg::SEQ_W-1:0]      seq_floor,
    output logic                           done,
    output logic [srw_pkg::STATUS_W-1:0]   status
);

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

    logic                          accept;
    logic                          src_ok;
    logic [IDX_W-1:0]              idx_in;
    srw_pkg::req_t                 req_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic                          req_valid_reg;
    srw_pkg::win_t                 win_rd;
    srw_pkg::win_t                 win_next;
    logic [srw_pkg::STATUS_W-1:0]  upd_status;
    logic                          wr_en;
    logic                          done_reg;
    logic [srw_pkg::STATUS_W-1:0]  status_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // source range check and window index
    assign src_ok = (source != '0) && (source <= srw_pkg::SRC_W'(NODES));
    assign idx_in = src_ok ? IDX_W'(source - srw_pkg::SRC_W'(1)) : '0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.src_ok       <= src_ok;
            req_reg.mode         <= mode;
            req_reg.msg_session  <= msg_session;
            req_reg.sequence_req <= sequence_req;
            req_reg.seq_floor    <= seq_floor;
            idx_reg              <= idx_in;
        end
    end

    srw_window_mem #(
        .NODES(NODES)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (idx_in),
        .rd_data (win_rd),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (win_next)
    );

    srw_window_update u_update (
        .win      (win_rd),
        .req      (req_reg),
        .status   (upd_status),
        .win_next (win_next)
    );

    // write back the window of every in-range request
    assign wr_en = req_valid_reg && req_reg.src_ok;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            status_reg <= req_reg.src_ok ? upd_status : srw_pkg::ST_BAD_ARGUMENT;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;

    // checks
    `SRW_ASSERT_NEXT(a_req_gives_result, clk, rst_n, req_valid_reg, done, "request lost")
    `SRW_ASSERT_NEXT(a_idle_no_result, clk, rst_n, !req_valid_reg, !done, "spurious result")
    `SRW_ASSERT_NEXT(a_bad_source, clk, rst_n, req_valid_reg && !req_reg.src_ok,
        status == srw_pkg::ST_BAD_ARGUMENT, "bad source not rejected")
    `SRW_ASSERT_NEXT(a_mark_ok, clk, rst_n,
        req_valid_reg && req_reg.src_ok && (req_reg.mode == srw_pkg::MODE_MARK),
        status == srw_pkg::ST_OK, "mark did not give ok")

endmodule

[src/srw_window_mem.sv]
// Window store: one entry per source, registered read with write forwarding.
`timescale 1ns / 1ps

module srw_window_mem #(
    parameter int unsigned NODES = srw_pkg::NODES_DEFAULT,
    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output srw_pkg::win_t       rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  srw_pkg::win_t       wr_data
);

    srw_pkg::win_t    mem [NODES];
    logic [NODES-1:0] valid_reg;
    srw_pkg::win_t    rd_data_reg;
    logic             rd_valid_reg;
    logic             fwd;

    // a read of the entry being written this cycle takes the new value
    assign fwd = wr_en && (wr_addr == rd_addr);

    // payload write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // valid bits: an entry never written reads as the reset window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // registered read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            rd_valid_reg <= fwd ? 1'b1 : valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= fwd ? wr_data : mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[src/srw_window_update.sv]
// Verdict and window update for one request against one window.
`timescale 1ns / 1ps

module srw_window_update (
    input  srw_pkg::win_t                 win,
    input  srw_pkg::req_t                 req,
    output logic [srw_pkg::STATUS_W-1:0]  status,
    output srw_pkg::win_t                 win_next
);

    logic [srw_pkg::SEQ_W-1:0] back;
    logic [srw_pkg::SEQ_W-1:0] step;
    logic                      back_far;
    logic                      step_far;
    logic                      seq_above;

    // distance behind / ahead of the highest recorded sequence
    assign back      = win.highest - req.sequence_req;
    assign step      = req.sequence_req - win.highest;
    assign back_far  = back >= srw_pkg::SEQ_W'(srw_pkg::WINDOW_SPAN);
    assign step_far  = step >= srw_pkg::SEQ_W'(srw_pkg::WINDOW_SPAN);
    assign seq_above = req.sequence_req > win.highest;

    always_comb
    begin
        win_next = win;
        status   = srw_pkg::ST_OK;
        case (req.mode)
            srw_pkg::MODE_CHECK:
            begin
                if (!win.approved || (win.session != req.msg_session))
                begin
                    status = srw_pkg::ST_SESSION_REQUIRED;
                end
                else if (req.sequence_req < win.seq_floor)
                begin
                    status = srw_pkg::ST_STALE;
                end
                else if (win.started && !seq_above)
                begin
                    if (back_far)
                    begin
                        status = srw_pkg::ST_STALE;
                    end
                    else if (win.bitmap[back[srw_pkg::BACK_W-1:0]])
                    begin
                        status = srw_pkg::ST_DUPLICATE;
                    end
                end
            end
            srw_pkg::MODE_MARK:
            begin
                if (!win.started)
                begin
                    win_next.highest = req.sequence_req;
                    win_next.bitmap  = srw_pkg::BIT0;
                    win_next.started = 1'b1;
                end
                else if (seq_above)
                begin
                    // slide forward; a long jump leaves only the newest bit
                    win_next.bitmap  = step_far ? srw_pkg::BIT0
                        : ((win.bitmap << step[srw_pkg::BACK_W-1:0]) | srw_pkg::BIT0);
                    win_next.highest = req.sequence_req;
                end
                else if (!back_far)
                begin
                    win_next.bitmap = win.bitmap
                        | (srw_pkg::BIT0 << back[srw_pkg::BACK_W-1:0]);
                end
            end
            srw_pkg::MODE_APPROVE:
            begin
                if (req.msg_session == '0)
                begin
                    status = srw_pkg::ST_BAD_ARGUMENT;
                end
                else if (win.approved && (req.msg_session <= win.session))
                begin
                    status = srw_pkg::ST_STALE;
                end
                else
                begin
                    win_next.approved  = 1'b1;
                    win_next.session   = req.msg_session;
                    win_next.seq_floor = req.seq_floor;
                    win_next.started   = 1'b0;
                    win_next.highest   = '0;
                    win_next.bitmap    = '0;
                end
            end
            default:
            begin
                status = srw_pkg::ST_BAD_ARGUMENT;
            end
        endcase
    end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the session replay window: directed table, then random requests.
`timescale 1ns / 1ps

module tb_top;

    localparam int NODES = srw_pkg::NODES_DEFAULT;

    // mode 3 has no meaning and must be refused
    localparam logic [srw_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    // whether a table row carries its own status or takes the predicted one
    localparam bit PINNED    = 1'b1;
    localparam bit PREDICTED = 1'b0;

    localparam int RANDOM_REQUESTS = 600;
    localparam int QUIET_FIRST     = 250;
    localparam int QUIET_LAST      = 400;

    // one request as driven, with an optional fixed status
    typedef struct packed {
        logic [srw_pkg::MODE_W-1:0]   mode;
        logic [srw_pkg::SRC_W-1:0]    source;
        logic [srw_pkg::SESS_W-1:0]   session;
        logic [srw_pkg::SEQ_W-1:0]    seq;
        logic [srw_pkg::SEQ_W-1:0]    floor;
        logic                         use_pin;
        logic [srw_pkg::STATUS_W-1:0] pin;
    } req_row_t;

    localparam int DIRECTED_ROWS = 26;

    // directed table; pinned rows give a status that follows plainly from the rules
    localparam req_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        // nothing approved after reset
        '{srw_pkg::MODE_CHECK, 8'd1, 32'd1, 16'd0, 16'd0, PINNED, srw_pkg::ST_SESSION_REQUIRED},
        // source out of range at both ends
        '{srw_pkg::MODE_CHECK, 8'd0, 32'd1, 16'd0, 16'd0, PINNED, srw_pkg::ST_BAD_ARGUMENT},
        '{srw_pkg::MODE_MARK, 8'd255, 32'd1, 16'd0, 16'd0, PINNED, srw_pkg::ST_BAD_ARGUMENT},
        '{srw_pkg::MODE_MARK, 8'd9, 32'd1, 16'd3, 16'd0, PINNED, srw_pkg::ST_BAD_ARGUMENT},
        // unused mode
        '{MODE_UNUSED, 8'd1, 32'd5, 16'd0, 16'd0, PINNED, srw_pkg::ST_BAD_ARGUMENT},
        // zero session refused
        '{srw_pkg::MODE_APPROVE, 8'd1, 32'd0, 16'd0, 16'd0, PINNED, srw_pkg::ST_BAD_ARGUMENT},
        '{srw_pkg::MODE_APPROVE, 8'd1, 32'd5, 16'd0, 16'd10, PINNED, srw_pkg::ST_OK},
        // same and older session are stale
        '{srw_pkg::MODE_APPROVE, 8'd1, 32'd5, 16'd0, 16'd0, PINNED, srw_pkg::ST_STALE},
        '{srw_pkg::MODE_APPROVE, 8'd1, 32'd4, 16'd0, 16'd0, PINNED, srw_pkg::ST_STALE},
        '{srw_pkg::MODE_CHECK, 8'd1, 32'd6, 16'd20, 16'd0, PINNED, srw_pkg::ST_SESSION_REQUIRED},
        // floor boundary
        '{srw_pkg::MODE_CHECK, 8'd1, 32'd5, 16'd9, 16'd0, PINNED, srw_pkg::ST_STALE},
        '{srw_pkg::MODE_CHECK, 8'd1, 32'd5, 16'd10, 16'd0, PINNED, srw_pkg::ST_OK},
        // first mark starts the window
        '{srw_pkg::MODE_MARK, 8'd1, 32'd5, 16'd100, 16'd0, PINNED, srw_pkg::ST_OK},
        '{srw_pkg::MODE_CHECK, 8'd1, 32'd5, 16'd100, 16'd0, PINNED, srw_pkg::ST_DUPLICATE},
        // window edge: 63 behind is inside, 64 behind is stale
        '{srw_pkg::MODE_CHECK, 8'd1, 32'd5, 16'd37, 16'd0, PREDICTED, srw_pkg::ST_OK},
        '{srw_pkg::MODE_CHECK, 8'd1, 32'd5, 16'd36, 16'd0, PINNED, srw_pkg::ST_STALE},
        '{srw_pkg::MODE_MARK, 8'd1, 32'd5, 16'd37, 16'd0, PINNED, srw_pkg::ST_OK},
        '{srw_pkg::MODE_CHECK, 8'd1, 32'd5, 16'd37, 16'd0, PREDICTED, srw_pkg::ST_OK},
        // slide by 63, then a jump far beyond the window
        '{srw_pkg::MODE_MARK, 8'd1, 32'd5, 16'd163, 16'd0, PINNED, srw_pkg::ST_OK},
        '{srw_pkg::MODE_CHECK, 8'd1, 32'd5, 16'd100, 16'd0, PREDICTED, srw_pkg::ST_OK},
        '{srw_pkg::MODE_MARK, 8'd1, 32'd5, 16'hFFFF, 16'd0, PINNED, srw_pkg::ST_OK},
        '{srw_pkg::MODE_CHECK, 8'd1, 32'd5, 16'hFFFF, 16'd0, PREDICTED, srw_pkg::ST_OK},
        // all-ones session and floor on the last source
        '{srw_pkg::MODE_APPROVE, 8'd8, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, PINNED, srw_pkg::ST_OK},
        '{srw_pkg::MODE_CHECK, 8'd8, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, PINNED, srw_pkg::ST_OK},
        '{srw_pkg::MODE_APPROVE, 8'd8, 32'hFFFF_FFFF, 16'd0, 16'd0, PINNED, srw_pkg::ST_STALE},
        // mark ignores approval and the floor, though seq 0 lies below the floor
        '{srw_pkg::MODE_MARK, 8'd8, 32'd0, 16'd0, 16'd0, PINNED, srw_pkg::ST_OK}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [srw_pkg::MODE_W-1:0]   mode;
    logic [srw_pkg::SRC_W-1:0]    source;
    logic [srw_pkg::SESS_W-1:0]   msg_session;
    logic [srw_pkg::SEQ_W-1:0]    sequence_req;
    logic [srw_pkg::SEQ_W-1:0]    seq_floor;
    logic                         done;
    logic [srw_pkg::STATUS_W-1:0] status;

    // fixed status travelling with the request, if any
    logic                         pin_valid;
    logic [srw_pkg::STATUS_W-1:0] pin_status;

    // predicted window of each source
    logic                            w_approved [NODES];
    logic [srw_pkg::SESS_W-1:0]      w_session  [NODES];
    logic [srw_pkg::SEQ_W-1:0]       w_floor    [NODES];
    logic                            w_started  [NODES];
    logic [srw_pkg::SEQ_W-1:0]       w_highest  [NODES];
    logic [srw_pkg::WINDOW_SPAN-1:0] w_bitmap   [NODES];

    logic [srw_pkg::STATUS_W-1:0] status_due [$];
    int unsigned                  error_count;

    session_replay_window #(.NODES(NODES)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .source       (source),
        .msg_session  (msg_session),
        .sequence_req (sequence_req),
        .seq_floor    (seq_floor),
        .done         (done),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic log_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // applies one request to the predicted windows and returns its status
    function automatic logic [srw_pkg::STATUS_W-1:0] filter_request(input req_row_t r);
        int unsigned i;
        int unsigned back;
        int unsigned step;
        if (r.source < 1 || r.source > NODES || r.mode == MODE_UNUSED)
            return srw_pkg::ST_BAD_ARGUMENT;
        i = r.source - 1;
        case (r.mode)
            srw_pkg::MODE_CHECK:
            begin
                if (!w_approved[i] || w_session[i] != r.session)
                    return srw_pkg::ST_SESSION_REQUIRED;
                if (r.seq < w_floor[i])
                    return srw_pkg::ST_STALE;
                if (w_started[i] && r.seq <= w_highest[i])
                begin
                    back = w_highest[i] - r.seq;
                    if (back >= srw_pkg::WINDOW_SPAN)
                        return srw_pkg::ST_STALE;
                    if (w_bitmap[i][back])
                        return srw_pkg::ST_DUPLICATE;
                end
                return srw_pkg::ST_OK;
            end
            srw_pkg::MODE_MARK:
            begin
                if (!w_started[i])
                begin
                    w_highest[i] = r.seq;
                    w_bitmap[i]  = srw_pkg::BIT0;
                    w_started[i] = 1'b1;
                end
                else if (r.seq > w_highest[i])
                begin
                    step = r.seq - w_highest[i];
                    w_bitmap[i]  = (step >= srw_pkg::WINDOW_SPAN) ? srw_pkg::BIT0
                        : ((w_bitmap[i] << step) | srw_pkg::BIT0);
                    w_highest[i] = r.seq;
                end
                else
                begin
                    back = w_highest[i] - r.seq;
                    if (back < srw_pkg::WINDOW_SPAN)
                        w_bitmap[i][back] = 1'b1;
                end
                return srw_pkg::ST_OK;
            end
            default:
            begin
                if (r.session == '0)
                    return srw_pkg::ST_BAD_ARGUMENT;
                if (w_approved[i] && r.session <= w_session[i])
                    return srw_pkg::ST_STALE;
                w_approved[i] = 1'b1;
                w_session[i]  = r.session;
                w_floor[i]    = r.floor;
                w_started[i]  = 1'b0;
                w_highest[i]  = '0;
                w_bitmap[i]   = '0;
                return srw_pkg::ST_OK;
            end
        endcase
    endfunction

    // mostly well-formed traffic: current session, sequences near the window
    function automatic req_row_t make_random_row();
        req_row_t    r;
        int unsigned i;
        int unsigned pick;
        r = '0;
        r.use_pin = PREDICTED;
        if ($urandom_range(0, 99) < 4)
            r.source = $urandom_range(0, 1) ? 8'd0
                : srw_pkg::SRC_W'($urandom_range(NODES + 1, 255));
        else
            r.source = srw_pkg::SRC_W'($urandom_range(1, NODES));
        i = (r.source >= 1 && r.source <= NODES) ? r.source - 1 : 0;

        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.mode = srw_pkg::MODE_CHECK;
        else if (pick < 80)
            r.mode = srw_pkg::MODE_MARK;
        else if (pick < 96)
            r.mode = srw_pkg::MODE_APPROVE;
        else
            r.mode = MODE_UNUSED;

        pick = $urandom_range(0, 99);
        if (r.mode == srw_pkg::MODE_APPROVE)
        begin
            if (pick < 70)
                r.session = w_session[i] + srw_pkg::SESS_W'($urandom_range(1, 3));
            else if (pick < 80)
                r.session = w_session[i];
            else if (pick < 90)
                r.session = $urandom;
            else
                r.session = '0;
        end
        else
            r.session = (pick < 85) ? w_session[i] : srw_pkg::SESS_W'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 70)
            r.seq = w_highest[i] + srw_pkg::SEQ_W'($urandom_range(0, 140))
                - srw_pkg::SEQ_W'(70);
        else if (pick < 80)
            r.seq = w_floor[i] + srw_pkg::SEQ_W'($urandom_range(0, 4)) - srw_pkg::SEQ_W'(2);
        else
            r.seq = srw_pkg::SEQ_W'($urandom_range(0, 65535));

        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.floor = '0;
        else if (pick < 80)
            r.floor = srw_pkg::SEQ_W'($urandom_range(0, 100));
        else
            r.floor = srw_pkg::SEQ_W'($urandom_range(0, 65535));
        return r;
    endfunction

    // presents one request, after a random gap if enabled, and holds it until taken
    task automatic send_request(input req_row_t r, input bit idle_en);
        while (idle_en && $urandom_range(0, 99) < 36)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        mode         <= r.mode;
        source       <= r.source;
        msg_session  <= r.session;
        sequence_req <= r.seq;
        seq_floor    <= r.floor;
        pin_valid    <= r.use_pin;
        pin_status   <= r.pin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // predict on acceptance, compare each strobed status with the oldest due
    always @(posedge clk)
    begin : result_check
        req_row_t                     seen;
        logic [srw_pkg::STATUS_W-1:0] predicted;
        logic [srw_pkg::STATUS_W-1:0] want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                seen = '{mode, source, msg_session, sequence_req, seq_floor,
                         pin_valid, pin_status};
                predicted = filter_request(seen);
                status_due.push_back(seen.use_pin ? seen.pin : predicted);
            end
            if (done)
            begin
                if (status_due.size() == 0)
                    log_mismatch($sformatf("status %0d with no request outstanding", status));
                else
                begin
                    want = status_due.pop_front();
                    if (status !== want)
                        log_mismatch($sformatf("status got %0d expected %0d", status, want));
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int n;
        error_count = 0;
        for (int k = 0; k < NODES; k++)
        begin
            w_approved[k] = 1'b0;
            w_session[k]  = '0;
            w_floor[k]    = '0;
            w_started[k]  = 1'b0;
            w_highest[k]  = '0;
            w_bitmap[k]   = '0;
        end
        rst_n        <= 1'b0;
        start        <= 1'b0;
        mode         <= srw_pkg::MODE_CHECK;
        source       <= '0;
        msg_session  <= '0;
        sequence_req <= '0;
        seq_floor    <= '0;
        pin_valid    <= PREDICTED;
        pin_status   <= srw_pkg::ST_OK;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int k = 0; k < DIRECTED_ROWS; k++)
            send_request(DIRECTED[k], 1'b1);

        // random traffic, with a quiet stretch of back-to-back requests
        for (int k = 0; k < RANDOM_REQUESTS; k++)
            send_request(make_random_row(), !(k >= QUIET_FIRST && k < QUIET_LAST));
        start <= 1'b0;

        // drain, then wait a while longer for anything stray
        n = 0;
        while (status_due.size() != 0 && n < 1000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
        if (status_due.size() != 0)
            log_mismatch($sformatf("%0d statuses never arrived", status_due.size()));

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
